// ===== rtl/core/nvqp_pkg.sv =====
// ----------------------------------------------------------------------------
// nvqp_pkg: shared types and constants of the NVMe I/O queue pair engine
// Item layouts, status codes, register indexes and ring geometry.
// ----------------------------------------------------------------------------
package nvqp_pkg;

	localparam int PAGE_BYTES = 4096;
	localparam int SQ_DEPTH   = 64;
	localparam int CQ_DEPTH   = 256;

	localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
	localparam int CALC_W    = 17;

	localparam logic [5:0] SQ_LAST = 6'(SQ_DEPTH - 1);
	localparam logic [7:0] CQ_LAST = 8'(CQ_DEPTH - 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE_LOG2     = 3'd0,
		CFG_MAX_TRANSFER_BLOCKS = 3'd1,
		CFG_NAMESPACE_ID        = 3'd2,
		CFG_SQ_LAST_INDEX       = 3'd3,
		CFG_CQ_LAST_INDEX       = 3'd4
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OP_SUBMIT     = 1'b0,
		OP_COMPLETION = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STS_SUBMITTED  = 3'd0,
		STS_ZERO_COUNT = 3'd1,
		STS_QUEUE_FULL = 3'd2,
		STS_NOT_READY  = 3'd3,
		STS_DONE_OK    = 3'd4,
		STS_DONE_ERROR = 3'd5
	} status_t;

	localparam logic [31:0] OPC_WRITE = 32'd1;
	localparam logic [31:0] OPC_READ  = 32'd2;
	localparam logic [31:0] D12_LIMITED_RETRY = 32'h8000_0000;

	// input tdata, lowest field in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [5:0]  cqe_sq_head;
		logic [15:0] cqe_status;
		logic [63:0] buffer_address;
		logic [15:0] block_count;
		logic [63:0] lba;
		logic        write;
	} in_item_t;

	// output tdata, lowest field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [15:0] blocks_done;
		logic [7:0]  cq_doorbell;
		logic [5:0]  sq_doorbell;
		logic [5:0]  sq_slot;
		logic [63:0] cmd_data_pointer;
		logic [31:0] cmd_dword12;
		logic [63:0] cmd_lba;
		logic [31:0] cmd_nsid;
		logic [31:0] cmd_dword0;
	} out_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

endpackage

// ===== rtl/core/nvme_io_queue_pair_engine.sv =====
// ----------------------------------------------------------------------------
// nvme_io_queue_pair_engine: host side of one NVMe I/O queue pair
// Builds read/write commands with tail doorbell, consumes completion entries.
// ----------------------------------------------------------------------------
// Result path: an accepted item enters the input register, then the result register.
// Throughput: one item per cycle unless the result stalls; pointers move as results load.
// A stalled result holds the result register, and the input register fills behind it.
// Reset: asynchronous, active low; tail, heads and pending count clear, phase sets,
// registers return to block size 512, max transfer 65535, nsid 1, full ring sizes.
module nvme_io_queue_pair_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nvqp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nvqp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// write, lba, block_count, buffer_address, cqe_status, cqe_sq_head, pad
	input  logic [nvqp_pkg::IN_W-1:0]      s_axis_tdata,
	// operation
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// cmd_dword0, cmd_nsid, cmd_lba, cmd_dword12, cmd_data_pointer, sq_slot,
	// sq_doorbell, cq_doorbell, blocks_done, pad
	output logic [nvqp_pkg::OUT_W-1:0]     m_axis_tdata,
	// status
	output logic [2:0]                     m_axis_tuser
);

	logic [3:0]  block_size_log2_q;
	logic [15:0] max_transfer_blocks_q;
	logic [31:0] namespace_id_q;
	logic [5:0]  sq_last_index_q;
	logic [7:0]  cq_last_index_q;

	logic [5:0]  sq_tail_q;
	logic [5:0]  sq_head_q;
	logic [7:0]  cq_head_q;
	logic        cq_phase_q;
	logic [15:0] pending_count_q;

	logic                valid_s1;
	nvqp_pkg::in_item_t  item_s1;
	nvqp_pkg::op_t       op_s1;
	logic                out_valid_q;
	nvqp_pkg::out_item_t out_q;
	nvqp_pkg::status_t   out_status_q;

	logic adv;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_log2_q     <= 4'd9;
			max_transfer_blocks_q <= 16'hFFFF;
			namespace_id_q        <= 32'd1;
			sq_last_index_q       <= 6'd63;
			cq_last_index_q       <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				nvqp_pkg::CFG_BLOCK_SIZE_LOG2:     block_size_log2_q     <= cfg_data[3:0];
				nvqp_pkg::CFG_MAX_TRANSFER_BLOCKS: max_transfer_blocks_q <= cfg_data[15:0];
				nvqp_pkg::CFG_NAMESPACE_ID:        namespace_id_q        <= cfg_data;
				nvqp_pkg::CFG_SQ_LAST_INDEX:       sq_last_index_q       <= cfg_data[5:0];
				nvqp_pkg::CFG_CQ_LAST_INDEX:       cq_last_index_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= nvqp_pkg::in_item_t'(s_axis_tdata);
			op_s1   <= nvqp_pkg::op_t'(s_axis_tuser);
		end
	end

	// combinational step on the item in the input register
	logic [5:0]                sql;
	logic [7:0]                cql;
	logic [5:0]                next_tail;
	logic [7:0]                next_cq_head;
	logic [nvqp_pkg::CALC_W-1:0] per_page;
	logic [nvqp_pkg::CALC_W-1:0] used;
	logic [nvqp_pkg::CALC_W-1:0] room;
	logic [nvqp_pkg::CALC_W-1:0] cnt_a;
	logic [nvqp_pkg::CALC_W-1:0] cnt_b;
	logic [15:0]               cnt;
	nvqp_pkg::status_t         status_c;
	nvqp_pkg::out_item_t       out_c;
	logic                      take_cmd;
	logic                      take_cqe;

	always_comb begin
		sql = (sq_last_index_q > nvqp_pkg::SQ_LAST) ? nvqp_pkg::SQ_LAST : sq_last_index_q;
		cql = (cq_last_index_q > nvqp_pkg::CQ_LAST) ? nvqp_pkg::CQ_LAST : cq_last_index_q;
		next_tail    = (sq_tail_q >= sql) ? 6'd0 : sq_tail_q + 6'd1;
		next_cq_head = (cq_head_q >= cql) ? 8'd0 : cq_head_q + 8'd1;

		per_page = nvqp_pkg::CALC_W'(nvqp_pkg::PAGE_BYTES) >> block_size_log2_q;
		used     = nvqp_pkg::CALC_W'(item_s1.buffer_address[nvqp_pkg::PAGE_LOG2-1:0])
		           >> block_size_log2_q;
		room     = per_page - used;
		cnt_a    = nvqp_pkg::CALC_W'(item_s1.block_count);
		if (cnt_a > room) cnt_a = room;
		cnt_b    = nvqp_pkg::CALC_W'(max_transfer_blocks_q);
		if (cnt_a > cnt_b) cnt_a = cnt_b;
		cnt = cnt_a[15:0];

		out_c    = '0;
		take_cmd = 1'b0;
		take_cqe = 1'b0;
		if (op_s1 == nvqp_pkg::OP_SUBMIT) begin
			if (cnt == 16'd0) begin
				status_c = nvqp_pkg::STS_ZERO_COUNT;
			end else if (next_tail == sq_head_q) begin
				status_c = nvqp_pkg::STS_QUEUE_FULL;
			end else begin
				status_c                 = nvqp_pkg::STS_SUBMITTED;
				take_cmd                 = 1'b1;
				out_c.sq_slot            = sq_tail_q;
				out_c.cmd_dword0         = (item_s1.write ? nvqp_pkg::OPC_WRITE
				                                          : nvqp_pkg::OPC_READ)
				                           | {10'd0, sq_tail_q, 16'd0};
				out_c.cmd_nsid           = namespace_id_q;
				out_c.cmd_lba            = item_s1.lba;
				out_c.cmd_dword12        = nvqp_pkg::D12_LIMITED_RETRY | {16'd0, cnt - 16'd1};
				out_c.cmd_data_pointer   = item_s1.buffer_address;
				out_c.blocks_done        = cnt;
			end
		end else begin
			if (item_s1.cqe_status[0] != cq_phase_q) begin
				status_c = nvqp_pkg::STS_NOT_READY;
			end else begin
				take_cqe = 1'b1;
				if (item_s1.cqe_status[8:1] != 8'd0) begin
					status_c = nvqp_pkg::STS_DONE_ERROR;
				end else begin
					status_c          = nvqp_pkg::STS_DONE_OK;
					out_c.blocks_done = pending_count_q;
				end
			end
		end
		out_c.sq_doorbell = take_cmd ? next_tail : sq_tail_q;
		out_c.cq_doorbell = take_cqe ? next_cq_head : cq_head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_tail_q       <= '0;
			sq_head_q       <= '0;
			cq_head_q       <= '0;
			cq_phase_q      <= 1'b1;
			pending_count_q <= '0;
		end else if (adv) begin
			if (take_cmd) begin
				sq_tail_q       <= next_tail;
				pending_count_q <= cnt;
			end
			if (take_cqe) begin
				cq_head_q <= next_cq_head;
				sq_head_q <= item_s1.cqe_sq_head;
				if (cq_head_q >= cql) cq_phase_q <= ~cq_phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q        <= out_c;
			out_status_q <= status_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// ===== rtl/core/nvqp_checker.sv =====
// ----------------------------------------------------------------------------
// nvqp_checker: port-level checks of the NVMe I/O queue pair engine
// Result stability under stall, status range, field consistency, idle ready.
// ----------------------------------------------------------------------------
module nvqp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [nvqp_pkg::OUT_W-1:0]      m_axis_tdata,
	input logic [2:0]                      m_axis_tuser
);

	nvqp_pkg::out_item_t o;
	assign o = nvqp_pkg::out_item_t'(m_axis_tdata);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= nvqp_pkg::STS_DONE_ERROR)
		else $error("status out of range");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != nvqp_pkg::STS_SUBMITTED |->
		o.cmd_dword0 == '0 && o.cmd_nsid == '0 && o.cmd_lba == '0 &&
		o.cmd_dword12 == '0 && o.cmd_data_pointer == '0 && o.sq_slot == '0)
		else $error("command fields set on a non-submit result");

	a_submit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == nvqp_pkg::STS_SUBMITTED |->
		o.blocks_done != 16'd0 && o.cmd_dword12[31] &&
		o.cmd_dword12[15:0] + 16'd1 == o.blocks_done &&
		o.cmd_dword0[21:16] == o.sq_slot)
		else $error("submitted command fields disagree");

	a_no_block_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

bind nvme_io_queue_pair_engine nvqp_checker u_nvqp_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the NVMe I/O queue pair engine
// Streams submit and completion items through the engine under a sequence of
// register settings, predicts every result from a cycle-free copy of the ring
// state, and compares each result field by field. Both stream sides idle at
// random, and the result side is held off for long stretches to fill the pipe.
// ----------------------------------------------------------------------------
module tb_top;
	import nvqp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 165;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [5:0]  sq_tail;
		logic [5:0]  sq_head;
		logic [7:0]  cq_head;
		logic        cq_phase;
		logic [15:0] pending;
	} ring_state_t;

	typedef struct packed {
		logic [3:0]  bs_log2;
		logic [15:0] max_xfer;
		logic [31:0] nsid;
		logic [5:0]  sq_last;
		logic [7:0]  cq_last;
	} qp_cfg_t;

	typedef struct packed {
		op_t      op;
		in_item_t d;
	} host_req_t;

	typedef struct packed {
		status_t   sts;
		out_item_t d;
	} qp_rsp_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic [2:0]            m_axis_tuser;

	logic rx_hold = 1'b0;
	logic calm = 1'b0;

	host_req_t   req_q[$];
	qp_rsp_t     expected_rsp_q[$];
	ring_state_t plan_st;
	ring_state_t pred_st;
	qp_cfg_t     cfg_m;
	host_req_t   on_bus;
	int          cmds_in_flight;
	int          items_queued;
	int          items_taken;
	int          results_seen;
	int          err_count;
	int          settings_used;
	int          cycles;
	int          tx_gap;
	int          rx_stall;
	int          status_hits [6];

	nvme_io_queue_pair_engine uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int ring_next(input int p, input int last);
		return (p >= last) ? 0 : p + 1;
	endfunction

	function automatic void predict_qp_step(inout ring_state_t st, input qp_cfg_t c,
			input op_t op, input in_item_t it, output qp_rsp_t r);
		int         per_page;
		int         used;
		int         grant;
		logic [5:0] nt;
		r = '0;
		if (op == OP_SUBMIT) begin
			per_page = PAGE_BYTES >> c.bs_log2;
			used = int'(it.buffer_address & 64'(PAGE_BYTES - 1)) >> c.bs_log2;
			grant = int'(it.block_count);
			if (grant > per_page - used) grant = per_page - used;
			if (grant > int'(c.max_xfer)) grant = int'(c.max_xfer);
			if (grant == 0) begin
				r.sts = STS_ZERO_COUNT;
			end else begin
				nt = 6'(ring_next(int'(st.sq_tail), int'(c.sq_last)));
				if (nt == st.sq_head) begin
					r.sts = STS_QUEUE_FULL;
				end else begin
					r.sts = STS_SUBMITTED;
					r.d.sq_slot = st.sq_tail;
					r.d.cmd_dword0 = (it.write ? OPC_WRITE : OPC_READ) | (32'(st.sq_tail) << 16);
					r.d.cmd_nsid = c.nsid;
					r.d.cmd_lba = it.lba;
					r.d.cmd_dword12 = D12_LIMITED_RETRY | 32'(16'(grant - 1));
					r.d.cmd_data_pointer = it.buffer_address;
					r.d.blocks_done = 16'(grant);
					st.pending = 16'(grant);
					st.sq_tail = nt;
				end
			end
		end else if (it.cqe_status[0] != st.cq_phase) begin
			r.sts = STS_NOT_READY;
		end else begin
			if (st.cq_head >= c.cq_last) st.cq_phase = ~st.cq_phase;
			st.cq_head = 8'(ring_next(int'(st.cq_head), int'(c.cq_last)));
			st.sq_head = it.cqe_sq_head;
			if (it.cqe_status[8:1] != 8'h00) begin
				r.sts = STS_DONE_ERROR;
			end else begin
				r.sts = STS_DONE_OK;
				r.d.blocks_done = st.pending;
			end
		end
		r.d.sq_doorbell = st.sq_tail;
		r.d.cq_doorbell = st.cq_head;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_CAP) $display("MISMATCH result %0d: %s", results_seen, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// driver: hold the item until taken, then predict it
	always @(posedge clk or negedge arst_n) begin
		qp_rsp_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_qp_step(pred_st, cfg_m, on_bus.op, on_bus.d, r);
				expected_rsp_q.push_back(r);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					on_bus = req_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= on_bus.d;
					s_axis_tuser <= on_bus.op;
					tx_gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		qp_rsp_t   e;
		out_item_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (m_axis_tuser < 3'd6) status_hits[m_axis_tuser]++;
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					e = expected_rsp_q.pop_front();
					if (status_t'(m_axis_tuser) !== e.sts)
						report_mismatch($sformatf("status got %0d want %s",
							m_axis_tuser, e.sts.name()));
					check_field("cmd_dword0", 64'(got.cmd_dword0), 64'(e.d.cmd_dword0));
					check_field("cmd_nsid", 64'(got.cmd_nsid), 64'(e.d.cmd_nsid));
					check_field("cmd_lba", got.cmd_lba, e.d.cmd_lba);
					check_field("cmd_dword12", 64'(got.cmd_dword12), 64'(e.d.cmd_dword12));
					check_field("cmd_data_pointer", got.cmd_data_pointer,
						e.d.cmd_data_pointer);
					check_field("sq_slot", 64'(got.sq_slot), 64'(e.d.sq_slot));
					check_field("sq_doorbell", 64'(got.sq_doorbell), 64'(e.d.sq_doorbell));
					check_field("cq_doorbell", 64'(got.cq_doorbell), 64'(e.d.cq_doorbell));
					check_field("blocks_done", 64'(got.blocks_done), 64'(e.d.blocks_done));
				end
				results_seen++;
			end
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = pick_gap();
			end
		end
	end

	// hold off the result side while items keep coming
	initial begin
		int marks [2];
		marks = '{300, 1000};
		foreach (marks[i]) begin
			while (items_taken < marks[i]) @(posedge clk);
			rx_hold <= 1'b1;
			repeat (400) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				expected_rsp_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_item(input op_t op, input in_item_t d);
		host_req_t q;
		qp_rsp_t   r;
		q.op = op;
		q.d = d;
		req_q.push_back(q);
		items_queued++;
		predict_qp_step(plan_st, cfg_m, op, d, r);
		if (r.sts == STS_SUBMITTED) cmds_in_flight++;
		if ((r.sts == STS_DONE_OK || r.sts == STS_DONE_ERROR) && cmds_in_flight > 0)
			cmds_in_flight--;
	endtask

	task automatic queue_submit(input logic wr, input logic [63:0] lba,
			input logic [15:0] cnt, input logic [63:0] addr);
		in_item_t d;
		d = '0;
		d.write = wr;
		d.lba = lba;
		d.block_count = cnt;
		d.buffer_address = addr;
		queue_item(OP_SUBMIT, d);
	endtask

	task automatic queue_cqe(input logic [15:0] sts, input logic [5:0] sqh);
		in_item_t d;
		d = '0;
		d.cqe_status = sts;
		d.cqe_sq_head = sqh;
		queue_item(OP_COMPLETION, d);
	endtask

	task automatic queue_random_item();
		in_item_t d;
		int       r;
		logic     full_now;
		logic     do_submit;
		d = '0;
		full_now = 6'(ring_next(int'(plan_st.sq_tail), int'(cfg_m.sq_last))) == plan_st.sq_head;
		r = $urandom_range(0, 99);
		if (cmds_in_flight == 0) do_submit = r < 85;
		else if (full_now) do_submit = r < 20;
		else do_submit = r < 55;
		if (do_submit) begin
			d.write = 1'($urandom);
			r = $urandom_range(0, 99);
			d.lba = (r < 10) ? '1 : (r < 20) ? '0 : rand64();
			r = $urandom_range(0, 99);
			d.buffer_address = rand64();
			if (r < 40) d.buffer_address[11:0] = '0;
			r = $urandom_range(0, 99);
			if (r < 10) d.block_count = '0;
			else if (r < 20) d.block_count = '1;
			else if (r < 30) d.block_count = 16'($urandom);
			else d.block_count = 16'($urandom_range(1, 8));
			d.cqe_status = 16'($urandom);
			d.cqe_sq_head = 6'($urandom);
			queue_item(OP_SUBMIT, d);
		end else begin
			d.cqe_status[15:9] = 7'($urandom);
			d.cqe_status[8:1] = ($urandom_range(0, 99) < 80) ? 8'h00 : 8'($urandom_range(1, 255));
			d.cqe_status[0] = ($urandom_range(0, 99) < 90) ? plan_st.cq_phase : ~plan_st.cq_phase;
			d.cqe_sq_head = ($urandom_range(0, 99) < 85) ? plan_st.sq_tail : 6'($urandom);
			d.write = 1'($urandom);
			d.lba = rand64();
			d.block_count = 16'($urandom);
			d.buffer_address = rand64();
			queue_item(OP_COMPLETION, d);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic apply_cfg(input qp_cfg_t c);
		write_reg(CFG_BLOCK_SIZE_LOG2, 32'(c.bs_log2));
		write_reg(CFG_MAX_TRANSFER_BLOCKS, 32'(c.max_xfer));
		write_reg(CFG_NAMESPACE_ID, c.nsid);
		write_reg(CFG_SQ_LAST_INDEX, 32'(c.sq_last));
		write_reg(CFG_CQ_LAST_INDEX, 32'(c.cq_last));
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_m = c;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || expected_rsp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		qp_cfg_t c;
		int      r;
		plan_st = '0;
		plan_st.cq_phase = 1'b1;
		pred_st = plan_st;
		cfg_m = '{bs_log2: 4'd9, max_xfer: 16'hFFFF, nsid: 32'd1, sq_last: 6'd63,
			cq_last: 8'd255};
		settings_used = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: counts, page clamps, phase and status variants
		queue_submit(1'b0, 64'h0, 16'h0000, 64'h0);
		queue_submit(1'b1, '1, 16'hFFFF, 64'h0);
		queue_submit(1'b0, 64'h0, 16'h0001, '1);
		queue_cqe(16'h0000, 6'd0);
		queue_cqe(16'h0001, 6'd2);
		queue_cqe(16'hFFFF, 6'h3F);
		queue_cqe(16'hFE01, 6'd2);
		wait_drained();

		// block larger than page, one-entry completion ring
		apply_cfg('{bs_log2: 4'd15, max_xfer: 16'd1, nsid: 32'd0, sq_last: 6'd0, cq_last: 8'd0});
		queue_submit(1'b1, rand64(), 16'd1, 64'h0);
		queue_cqe({15'h0, plan_st.cq_phase}, 6'd0);
		queue_cqe({15'h0, plan_st.cq_phase}, 6'd0);
		queue_cqe({15'h0, ~plan_st.cq_phase}, 6'd0);
		wait_drained();

		// zero transfer limit
		apply_cfg('{bs_log2: 4'd0, max_xfer: 16'd0, nsid: '1, sq_last: 6'd1, cq_last: 8'd1});
		queue_submit(1'b0, rand64(), 16'hFFFF, 64'h0);
		queue_cqe({15'h0, plan_st.cq_phase}, 6'd0);
		wait_drained();

		// one block per page, two-entry rings running full
		apply_cfg('{bs_log2: 4'd12, max_xfer: 16'hFFFF, nsid: 32'hFFFF_FFFE, sq_last: 6'd1,
			cq_last: 8'd1});
		queue_submit(1'b1, rand64(), 16'd5, 64'h0000_1234_5678_9FFF);
		queue_submit(1'b0, rand64(), 16'd1, rand64());
		queue_cqe({15'h0, plan_st.cq_phase}, plan_st.sq_tail);
		queue_submit(1'b1, rand64(), 16'd2, rand64());
		queue_submit(1'b0, rand64(), 16'd1, rand64());
		wait_drained();

		// one-entry submission ring, head moved off zero
		apply_cfg('{bs_log2: 4'd0, max_xfer: 16'hFFFF, nsid: $urandom, sq_last: 6'd0,
			cq_last: 8'd255});
		queue_submit(1'b0, rand64(), 16'd1, 64'h0);
		queue_cqe({15'h0, plan_st.cq_phase}, 6'd5);
		queue_submit(1'b1, rand64(), 16'hFFFF, 64'h0);
		queue_submit(1'b0, rand64(), 16'd4096, 64'h0);
		wait_drained();

		for (int k = 0; k < RAND_PHASES; k++) begin
			if (k == 0) begin
				c = '{bs_log2: 4'd12, max_xfer: 16'hFFFF, nsid: '1, sq_last: 6'd63, cq_last: 8'd255};
			end else if (k == 1) begin
				c = '{bs_log2: 4'd0, max_xfer: 16'd1, nsid: 32'd1, sq_last: 6'd1, cq_last: 8'd1};
			end else begin
				r = $urandom_range(0, 99);
				c.bs_log2 = (r < 70) ? 4'($urandom_range(6, 12)) : 4'($urandom_range(0, 15));
				r = $urandom_range(0, 99);
				c.max_xfer = (r < 15) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(1, 65535));
				c.nsid = $urandom;
				c.sq_last = ($urandom_range(0, 99) < 40) ? 6'($urandom_range(1, 3)) : 6'($urandom);
				c.cq_last = ($urandom_range(0, 99) < 40) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			end
			@(posedge clk);
			calm <= (k == 3 || k == 6);
			apply_cfg(c);
			for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (expected_rsp_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
		$display("Ran %0d items under %0d register settings, %0d mismatches", items_taken,
			settings_used, err_count);
		$display("Results: %0d submitted, %0d zero count, %0d ring full, %0d not ready, %0d ok, %0d error",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
			status_hits[5]);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
